[rtl/sgbs_pkg.sv]
// Package for the staggered-grid bilinear sampler.
// Holds payload structs, mode and register codes, sequencer states and default sizes.
// No dependencies.
package sgbs_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int DATA_W  = 16;
    localparam int CFG_W   = 7;
    localparam int IDX_W   = CFG_W + 1;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        MODE_WRITE_EDGE = 2'd0,
        MODE_SET_CELL   = 2'd1,
        MODE_GET_CELL   = 2'd2,
        MODE_SAMPLE     = 2'd3
    } mode_t;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic COMP_HORIZONTAL = 1'b0;

    typedef struct packed {
        mode_t                     mode;
        logic                      component;
        logic [CFG_W-1:0]          col;
        logic [CFG_W-1:0]          row;
        logic signed [DATA_W-1:0]  edge_value;
        logic signed [DATA_W-1:0]  cell_x;
        logic signed [DATA_W-1:0]  cell_y;
        logic signed [DATA_W-1:0]  pos_x;
        logic signed [DATA_W-1:0]  pos_y;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  out_x;
        logic signed [DATA_W-1:0]  out_y;
        logic                      index_error;
    } result_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ACCESS = 7'b0000010,
        ST_TAIL   = 7'b0000100,
        ST_MUL1   = 7'b0001000,
        ST_ADD1   = 7'b0010000,
        ST_MUL2   = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

endpackage

[rtl/sgbs_edge_ram.sv]
// Single-port synchronous edge store with a registered read.
// Depends on sgbs_pkg for the data width.
module sgbs_edge_ram #(
    parameter int DEPTH  = 4225,
    parameter int ADDR_W = 13
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [ADDR_W-1:0]                addr,
    input  logic [sgbs_pkg::DATA_W-1:0]      wdata,
    output logic [sgbs_pkg::DATA_W-1:0]      rdata
);
    import sgbs_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/staggered_grid_bilinear_sampler.sv]
// Staggered-grid velocity store with cell get/set and bilinear sampling.
// Depends on sgbs_pkg and sgbs_edge_ram.
//
//  Channel  | Signals                                   | Beat moves
//  item     | item_valid, item_ready, item              | one request
//  result   | result_valid, result_ready, result        | one get or sample answer
//  config   | psel, penable, pwrite, paddr, pwdata, ...  | one register access
//
// Get and sample items wait in ST_FIN while an earlier result is still stalled at the output.
// Each edge memory has a single port, so a sample reads its four neighbours one at a time.
// One item is in work at a time; a new item is taken while a result waits.
// Reset clears control state and sets the grid size registers to 64; edge memories are not cleared.
module staggered_grid_bilinear_sampler #(
    parameter int MAX_WIDTH  = sgbs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sgbs_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = sgbs_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  sgbs_pkg::item_t                item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output sgbs_pkg::result_t              result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sgbs_pkg::PADDR_W-1:0]   paddr,
    input  logic [sgbs_pkg::PDATA_W-1:0]   pwdata,
    output logic [sgbs_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import sgbs_pkg::*;

    localparam int STRIDE = MAX_WIDTH + 1;
    localparam int DEPTH  = STRIDE * (MAX_HEIGHT + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = CFG_W + FRAC_BITS + 1;
    localparam int PW     = (CW > DATA_W) ? CW : DATA_W;
    localparam int HALF   = 1 << (FRAC_BITS - 1);
    localparam int DW     = DATA_W + 1;
    localparam int PRW    = DW + FRAC_BITS + 1;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] grid_width_reg, grid_height_reg;
    logic [CFG_W-1:0] w_eff, h_eff;

    item_t            item_reg;
    logic [IDX_W-1:0] h_c0_reg, h_r0_reg, v_c0_reg, v_r0_reg;
    logic [FRAC_BITS-1:0] tx_h_reg, ty_h_reg, tx_v_reg, ty_v_reg;
    logic             wr_h_ok_reg, wr_v_ok_reg, err_reg;
    logic [DATA_W-1:0] wd_h_reg, wd_v_reg;
    logic [1:0]       step_reg, last_reg;
    logic             rd_pend_reg;
    logic [1:0]       rd_idx_reg;

    logic signed [DATA_W-1:0] nb_h_reg [4];
    logic signed [DATA_W-1:0] nb_v_reg [4];
    logic signed [PRW-1:0]    p_he_reg, p_hf_reg, p_ve_reg, p_vf_reg;
    logic signed [DATA_W-1:0] e_h_reg, f_h_reg, e_v_reg, f_v_reg;
    logic signed [PRW-1:0]    p_hg_reg, p_vg_reg;

    logic    out_valid_reg;
    result_t out_reg;

    logic              we_h, we_v;
    logic [ADDR_W-1:0] addr_h, addr_v;
    logic [DATA_W-1:0] rd_h, rd_v;
    logic              accept, load_out, cfg_wr;

    // Accept-time decode.
    logic [CW-1:0]    hi_x, hi_y, cx, cy, hx, vy;
    logic [PW-1:0]    px_u, py_u;
    logic             in_cell;
    logic [IDX_W-1:0] col_e, row_e;

    assign accept     = item_valid && item_ready;
    assign item_ready = (state_reg == ST_IDLE);
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_GRID_HEIGHT) ? PDATA_W'(grid_height_reg)
                                                     : PDATA_W'(grid_width_reg);

    assign w_eff = (grid_width_reg < CFG_W'(2)) ? CFG_W'(2) :
                   (32'(grid_width_reg) > 32'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : grid_width_reg;
    assign h_eff = (grid_height_reg < CFG_W'(2)) ? CFG_W'(2) :
                   (32'(grid_height_reg) > 32'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : grid_height_reg;

    always_comb
    begin
        hi_x = CW'(w_eff - CFG_W'(2)) << FRAC_BITS;
        hi_y = CW'(h_eff - CFG_W'(2)) << FRAC_BITS;
        px_u = PW'(item.pos_x[DATA_W-2:0]);
        py_u = PW'(item.pos_y[DATA_W-2:0]);
        if (item.pos_x[DATA_W-1])
        begin
            cx = '0;
        end
        else if (px_u > PW'(hi_x))
        begin
            cx = hi_x;
        end
        else
        begin
            cx = CW'(px_u);
        end
        if (item.pos_y[DATA_W-1])
        begin
            cy = '0;
        end
        else if (py_u > PW'(hi_y))
        begin
            cy = hi_y;
        end
        else
        begin
            cy = CW'(py_u);
        end
        hx      = cx + CW'(HALF);
        vy      = cy + CW'(HALF);
        in_cell = (item.col < w_eff) && (item.row < h_eff);
        col_e   = IDX_W'(item.col);
        row_e   = IDX_W'(item.row);
    end

    // Per-step addressing: in samples bit 0 steps column, bit 1 row; else bit 0 steps h col, v row.
    logic [IDX_W-1:0] h_col, h_row, v_col, v_row;
    logic             is_sample, in_access, last_step;

    always_comb
    begin
        is_sample = (item_reg.mode == MODE_SAMPLE);
        in_access = (state_reg == ST_ACCESS);
        last_step = (step_reg == last_reg);
        h_col = h_c0_reg + IDX_W'(step_reg[0]);
        h_row = h_r0_reg + (is_sample ? IDX_W'(step_reg[1]) : '0);
        v_col = v_c0_reg + (is_sample ? IDX_W'(step_reg[0]) : '0);
        v_row = v_r0_reg + (is_sample ? IDX_W'(step_reg[1]) : IDX_W'(step_reg[0]));
        addr_h = ADDR_W'(32'(h_row) * 32'(STRIDE) + 32'(h_col));
        addr_v = ADDR_W'(32'(v_row) * 32'(STRIDE) + 32'(v_col));
        we_h = in_access && wr_h_ok_reg;
        we_v = in_access && wr_v_ok_reg;
    end

    sgbs_edge_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_h_ram (
        .clk   (clk),
        .we    (we_h),
        .addr  (addr_h),
        .wdata (wd_h_reg),
        .rdata (rd_h)
    );

    sgbs_edge_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_v_ram (
        .clk   (clk),
        .we    (we_v),
        .addr  (addr_v),
        .wdata (wd_v_reg),
        .rdata (rd_v)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                if (last_step)
                begin
                    if (item_reg.mode == MODE_WRITE_EDGE || item_reg.mode == MODE_SET_CELL)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_TAIL:   state_next = is_sample ? ST_MUL1 : ST_FIN;
            ST_MUL1:   state_next = ST_ADD1;
            ST_ADD1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_FIN;
            ST_FIN:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            grid_width_reg  <= CFG_W'(64);
            grid_height_reg <= CFG_W'(64);
            step_reg        <= '0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= in_access;
            if (cfg_wr)
            begin
                if (paddr[2] == REG_GRID_WIDTH)
                begin
                    grid_width_reg <= pwdata[CFG_W-1:0];
                end
                else
                begin
                    grid_height_reg <= pwdata[CFG_W-1:0];
                end
            end
            if (accept)
            begin
                step_reg <= '0;
            end
            else if (in_access)
            begin
                step_reg <= step_reg + 2'd1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    logic [PRW-1:0] sum_eh, sum_fh, sum_ev, sum_fv, sum_gh, sum_gv;
    logic [DW-1:0]  avg_h, avg_v;

    always_comb
    begin
        sum_eh = PRW'(nb_h_reg[0]) + PRW'(p_he_reg >>> FRAC_BITS);
        sum_fh = PRW'(nb_h_reg[2]) + PRW'(p_hf_reg >>> FRAC_BITS);
        sum_ev = PRW'(nb_v_reg[0]) + PRW'(p_ve_reg >>> FRAC_BITS);
        sum_fv = PRW'(nb_v_reg[2]) + PRW'(p_vf_reg >>> FRAC_BITS);
        sum_gh = PRW'(e_h_reg) + PRW'(p_hg_reg >>> FRAC_BITS);
        sum_gv = PRW'(e_v_reg) + PRW'(p_vg_reg >>> FRAC_BITS);
        avg_h  = DW'(nb_h_reg[0]) + DW'(nb_h_reg[1]);
        avg_v  = DW'(nb_v_reg[0]) + DW'(nb_v_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
            wd_h_reg <= (item.mode == MODE_SET_CELL) ? item.cell_x : item.edge_value;
            wd_v_reg <= (item.mode == MODE_SET_CELL) ? item.cell_y : item.edge_value;
            err_reg  <= !in_cell;
            case (item.mode)
                MODE_WRITE_EDGE:
                begin
                    last_reg    <= 2'd0;
                    wr_h_ok_reg <= (item.component == COMP_HORIZONTAL) &&
                                   (item.col <= w_eff) && (item.row < h_eff);
                    wr_v_ok_reg <= (item.component != COMP_HORIZONTAL) &&
                                   (item.col < w_eff) && (item.row <= h_eff);
                end
                MODE_SET_CELL:
                begin
                    last_reg    <= 2'd1;
                    wr_h_ok_reg <= in_cell;
                    wr_v_ok_reg <= in_cell;
                end
                MODE_GET_CELL:
                begin
                    last_reg    <= 2'd1;
                    wr_h_ok_reg <= 1'b0;
                    wr_v_ok_reg <= 1'b0;
                end
                default:
                begin
                    last_reg    <= 2'd3;
                    wr_h_ok_reg <= 1'b0;
                    wr_v_ok_reg <= 1'b0;
                end
            endcase
            if (item.mode == MODE_SAMPLE)
            begin
                h_c0_reg <= hx[CW-1:FRAC_BITS];
                h_r0_reg <= cy[CW-1:FRAC_BITS];
                v_c0_reg <= cx[CW-1:FRAC_BITS];
                v_r0_reg <= vy[CW-1:FRAC_BITS];
            end
            else
            begin
                h_c0_reg <= col_e;
                h_r0_reg <= row_e;
                v_c0_reg <= col_e;
                v_r0_reg <= row_e;
            end
            tx_h_reg <= hx[FRAC_BITS-1:0];
            ty_h_reg <= cy[FRAC_BITS-1:0];
            tx_v_reg <= cx[FRAC_BITS-1:0];
            ty_v_reg <= vy[FRAC_BITS-1:0];
        end
        rd_idx_reg <= step_reg;
        if (rd_pend_reg)
        begin
            nb_h_reg[rd_idx_reg] <= rd_h;
            nb_v_reg[rd_idx_reg] <= rd_v;
        end
        if (state_reg == ST_MUL1)
        begin
            p_he_reg <= PRW'((DW'(nb_h_reg[1]) - DW'(nb_h_reg[0])) * $signed({1'b0, tx_h_reg}));
            p_hf_reg <= PRW'((DW'(nb_h_reg[3]) - DW'(nb_h_reg[2])) * $signed({1'b0, tx_h_reg}));
            p_ve_reg <= PRW'((DW'(nb_v_reg[1]) - DW'(nb_v_reg[0])) * $signed({1'b0, tx_v_reg}));
            p_vf_reg <= PRW'((DW'(nb_v_reg[3]) - DW'(nb_v_reg[2])) * $signed({1'b0, tx_v_reg}));
        end
        if (state_reg == ST_ADD1)
        begin
            e_h_reg <= sum_eh[DATA_W-1:0];
            f_h_reg <= sum_fh[DATA_W-1:0];
            e_v_reg <= sum_ev[DATA_W-1:0];
            f_v_reg <= sum_fv[DATA_W-1:0];
        end
        if (state_reg == ST_MUL2)
        begin
            p_hg_reg <= PRW'((DW'(f_h_reg) - DW'(e_h_reg)) * $signed({1'b0, ty_h_reg}));
            p_vg_reg <= PRW'((DW'(f_v_reg) - DW'(e_v_reg)) * $signed({1'b0, ty_v_reg}));
        end
        if (load_out)
        begin
            if (is_sample)
            begin
                out_reg.out_x       <= sum_gh[DATA_W-1:0];
                out_reg.out_y       <= sum_gv[DATA_W-1:0];
                out_reg.index_error <= 1'b0;
            end
            else if (err_reg)
            begin
                out_reg.out_x       <= '0;
                out_reg.out_y       <= '0;
                out_reg.index_error <= 1'b1;
            end
            else
            begin
                out_reg.out_x       <= avg_h[DW-1:1];
                out_reg.out_y       <= avg_v[DW-1:1];
                out_reg.index_error <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[rtl/sgbs_checker.sv]
// Port-level checks for the staggered-grid bilinear sampler, bound to the top level.
// Depends on sgbs_pkg and staggered_grid_bilinear_sampler.
module sgbs_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic                           item_ready,
    input  sgbs_pkg::item_t                item,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  sgbs_pkg::result_t              result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sgbs_pkg::PADDR_W-1:0]   paddr,
    input  logic [sgbs_pkg::PDATA_W-1:0]   pwdata,
    input  logic [sgbs_pkg::PDATA_W-1:0]   prdata,
    input  logic                           pready
);
    import sgbs_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.index_error |-> result.out_x == '0 && result.out_y == '0)
        else $error("index error with nonzero result");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("second item taken while one is in work");

    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.mode == MODE_WRITE_EDGE && !result_valid
        |=> !result_valid)
        else $error("result appeared after an edge write");

endmodule

bind staggered_grid_bilinear_sampler sgbs_checker u_sgbs_checker (.*);
